FILE: hdl/agp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// agp_pkg: shared constants for the antialiased glyph pixel unit
// Default geometry, register indexes, reset colors and channel slots.
// ============================================================================

package agp_pkg;

    // default overlay size in pixels and subsamples per pixel edge
    localparam int OVERLAY_PIXELS_DEF = 32;
    localparam int SUBSAMPLES_DEF     = 4;

    localparam int PIX_W     = 5;   // pixel coordinate width
    localparam int COLOR_W   = 24;  // packed red/green/blue
    localparam int CH_W      = 8;   // one color channel
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLYPH_MODE  = 2'd0,
        CFG_DISC_COLOR  = 2'd1,
        CFG_GLYPH_COLOR = 2'd2
    } cfg_index_t;

    localparam logic                GLYPH_MODE_RST  = 1'b0;   // play triangle
    localparam logic [COLOR_W-1:0]  DISC_COLOR_RST  = 24'h18181A;
    localparam logic [COLOR_W-1:0]  GLYPH_COLOR_RST = 24'hF5F5F5;

    // result channel slots; blue/green/red match the byte order of a packed color
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;
    localparam int CH_ALPHA = 3;
    localparam int NUM_CH   = 4;

    // percent of the overlay span in 1/64-pixel units, rounded half up
    function automatic int frac_u(input int units, input int percent);
        return (2 * units * percent + 100) / 200;
    endfunction

endpackage

FILE: hdl/antialiased_glyph_pixel_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// antialiased_glyph_pixel_unit: premultiplied BGRA of one overlay pixel
// Supersampled coverage of a disc with a light ring and a play or pause glyph.
// ============================================================================
//
//  channel | signals                                   | transfer
//  --------+-------------------------------------------+---------------------------
//  pixel   | in_valid, in_ready, pixel_x, pixel_y      | valid & ready at clk rise
//  result  | out_valid, out_ready, blue/green/red/     | valid & ready at clk rise
//          | alpha_out                                 |
//  config  | cfg_we, cfg_index, cfg_data               | cfg_we at clk rise
//
//  Six register stages; a pixel transaction passes through them in order.
//  One pixel per cycle sustained while results are taken: every stage holds
//  one pixel, set by the six-stage pipeline with per-stage valid bits.
//  A stalled result only holds the stages it blocks; empty stages upstream
//  keep taking new pixels, and in_ready falls only once every stage is full.
//  Reset (rst_n low, asynchronous) empties the pipeline and restores the
//  registers: play glyph, disc 0x18181A, ring and glyph 0xF5F5F5.
//
//  Stage plan:
//    1  per sample column / row: coordinate, squared offset from center,
//       triangle edge terms, pause bar column / row tests
//    2  per subsample: coverage, ring, glyph hit
//    3  count covered and glyph-colored subsamples
//    4  channel sums (glyph color * hits + disc color * rest), alpha numerator
//    5  rounding numerator times reciprocal of twice the sample count
//    6  quotient into the output register
// ============================================================================

module antialiased_glyph_pixel_unit #(
    parameter int OVERLAY_PIXELS = agp_pkg::OVERLAY_PIXELS_DEF,
    parameter int SUBSAMPLES     = agp_pkg::SUBSAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [agp_pkg::PIX_W-1:0]     pixel_x,
    input  logic [agp_pkg::PIX_W-1:0]     pixel_y,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [agp_pkg::CH_W-1:0]      blue_out,
    output logic [agp_pkg::CH_W-1:0]      green_out,
    output logic [agp_pkg::CH_W-1:0]      red_out,
    output logic [agp_pkg::CH_W-1:0]      alpha_out,

    input  logic                          cfg_we,
    input  logic [agp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [agp_pkg::COLOR_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // Geometry, all in 1/64-pixel units
    // ------------------------------------------------------------------
    localparam int  UNITS   = 64 * OVERLAY_PIXELS;
    localparam int  CENTRE  = UNITS / 2;
    localparam int  RADIUS  = 32 * (OVERLAY_PIXELS - 2);
    localparam longint OUTER2 = longint'(RADIUS + 64) * longint'(RADIUS + 64);
    localparam longint INNER2 = longint'(RADIUS - 64) * longint'(RADIUS - 64);

    // signed coordinate width: holds the overlay span and any sample point
    localparam int  CW_G  = $clog2(UNITS) + 2;
    localparam int  CW    = (CW_G > 13) ? CW_G : 13;
    localparam int  PW    = 2 * CW;      // products
    localparam int  D2_W  = 2 * CW;      // one squared offset
    localparam int  EW    = 2 * CW + 1;  // edge function

    localparam logic signed [CW-1:0] CENTRE_V = CW'(CENTRE);
    localparam logic [D2_W:0]        OUTER2_V = (D2_W + 1)'(OUTER2);
    localparam logic [D2_W:0]        INNER2_V = (D2_W + 1)'(INNER2);

    // play triangle corners
    localparam int LX = agp_pkg::frac_u(UNITS, 35);
    localparam int TY = agp_pkg::frac_u(UNITS, 31);
    localparam int RX = agp_pkg::frac_u(UNITS, 73);
    localparam int MY = agp_pkg::frac_u(UNITS, 50);
    localparam int BY = agp_pkg::frac_u(UNITS, 69);

    // edge function = row term + column term
    //   edge 0 (LX,TY)->(RX,MY), edge 1 (RX,MY)->(LX,BY), edge 2 (LX,BY)->(LX,TY)
    localparam logic signed [CW-1:0] LX_V  = CW'(LX);
    localparam logic signed [CW-1:0] RX_V  = CW'(RX);
    localparam logic signed [CW-1:0] TY_V  = CW'(TY);
    localparam logic signed [CW-1:0] MY_V  = CW'(MY);
    localparam logic signed [CW-1:0] E0_DX = CW'(RX - LX);
    localparam logic signed [CW-1:0] E0_DY = CW'(MY - TY);
    localparam logic signed [CW-1:0] E1_DX = CW'(LX - RX);
    localparam logic signed [CW-1:0] E1_DY = CW'(BY - MY);
    localparam logic signed [CW-1:0] E2_DY = CW'(TY - BY);

    // pause bars
    localparam logic signed [CW-1:0] BAR_X0 = CW'(agp_pkg::frac_u(UNITS, 26));
    localparam logic signed [CW-1:0] BAR_X1 = CW'(agp_pkg::frac_u(UNITS, 40));
    localparam logic signed [CW-1:0] BAR_X2 = CW'(agp_pkg::frac_u(UNITS, 60));
    localparam logic signed [CW-1:0] BAR_X3 = CW'(agp_pkg::frac_u(UNITS, 74));
    localparam logic signed [CW-1:0] BAR_Y0 = CW'(agp_pkg::frac_u(UNITS, 30));
    localparam logic signed [CW-1:0] BAR_Y1 = CW'(agp_pkg::frac_u(UNITS, 70));

    // ------------------------------------------------------------------
    // Resolve: round(n / TOTAL) = floor((2n + TOTAL) / (2 TOTAL)),
    // done as an exact multiply by a rounded-up reciprocal
    // ------------------------------------------------------------------
    localparam int     TOTAL  = SUBSAMPLES * SUBSAMPLES;
    localparam int     CNT_W  = $clog2(TOTAL + 1);
    localparam int     SUM_W  = $clog2(255 * TOTAL + 1);
    localparam int     NUM_W  = SUM_W + 2;
    localparam int     DIVR   = 2 * TOTAL;
    localparam int     RSH    = NUM_W + $clog2(DIVR);
    localparam longint RECIP  = ((longint'(1) << RSH) + DIVR - 1) / DIVR;
    localparam int     PROD_W = 2 * NUM_W + 1;
    localparam logic [PROD_W-1:0] RECIP_V = PROD_W'(RECIP);
    localparam int     CH_W   = agp_pkg::CH_W;
    localparam int     NUM_CH = agp_pkg::NUM_CH;

    localparam int NSTG = 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                          glyph_mode_reg;
    logic [agp_pkg::COLOR_W-1:0]   disc_color_reg;
    logic [agp_pkg::COLOR_W-1:0]   glyph_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_mode_reg  <= agp_pkg::GLYPH_MODE_RST;
            disc_color_reg  <= agp_pkg::DISC_COLOR_RST;
            glyph_color_reg <= agp_pkg::GLYPH_COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                agp_pkg::CFG_GLYPH_MODE:  glyph_mode_reg  <= cfg_data[0];
                agp_pkg::CFG_DISC_COLOR:  disc_color_reg  <= cfg_data;
                agp_pkg::CFG_GLYPH_COLOR: glyph_color_reg <= cfg_data;
                default:                  ;   // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its successor
    // loads, so bubbles collapse behind a stalled result
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] stg_en;

    always_comb
    begin
        stg_en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            stg_en[k] = !vld_reg[k] || stg_en[k+1];
        end
    end

    assign in_ready  = stg_en[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stg_en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (stg_en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: per sample column and per sample row
    // ------------------------------------------------------------------
    logic [D2_W-1:0]        dx2_next [SUBSAMPLES];
    logic [D2_W-1:0]        dx2_reg  [SUBSAMPLES];
    logic [D2_W-1:0]        dy2_next [SUBSAMPLES];
    logic [D2_W-1:0]        dy2_reg  [SUBSAMPLES];
    logic signed [PW-1:0]   cx0_next [SUBSAMPLES];
    logic signed [PW-1:0]   cx0_reg  [SUBSAMPLES];
    logic signed [PW-1:0]   cx1_next [SUBSAMPLES];
    logic signed [PW-1:0]   cx1_reg  [SUBSAMPLES];
    logic signed [PW-1:0]   cx2_next [SUBSAMPLES];
    logic signed [PW-1:0]   cx2_reg  [SUBSAMPLES];
    logic signed [PW-1:0]   ry0_next [SUBSAMPLES];
    logic signed [PW-1:0]   ry0_reg  [SUBSAMPLES];
    logic signed [PW-1:0]   ry1_next [SUBSAMPLES];
    logic signed [PW-1:0]   ry1_reg  [SUBSAMPLES];
    logic [SUBSAMPLES-1:0]  colx_next;
    logic [SUBSAMPLES-1:0]  colx_reg;
    logic [SUBSAMPLES-1:0]  rowy_next;
    logic [SUBSAMPLES-1:0]  rowy_reg;

    for (genvar k = 0; k < SUBSAMPLES; k++)
    begin : g_lane
        // sample offset inside the pixel, rounded half up
        localparam int OFF = (64 * (2 * k + 1) + SUBSAMPLES) / (2 * SUBSAMPLES);

        logic signed [CW-1:0] x_c;
        logic signed [CW-1:0] y_c;
        logic signed [CW-1:0] dx_c;
        logic signed [CW-1:0] dy_c;
        logic signed [PW-1:0] sqx_c;
        logic signed [PW-1:0] sqy_c;

        assign x_c  = CW'({pixel_x, 6'd0}) + CW'(OFF);
        assign y_c  = CW'({pixel_y, 6'd0}) + CW'(OFF);
        assign dx_c = x_c - CENTRE_V;
        assign dy_c = y_c - CENTRE_V;

        assign sqx_c = PW'(dx_c) * PW'(dx_c);
        assign sqy_c = PW'(dy_c) * PW'(dy_c);
        assign dx2_next[k] = $unsigned(sqx_c);
        assign dy2_next[k] = $unsigned(sqy_c);

        assign cx0_next[k] = PW'(E0_DY) * PW'(LX_V - x_c);
        assign cx1_next[k] = PW'(E1_DY) * PW'(RX_V - x_c);
        assign cx2_next[k] = PW'(E2_DY) * PW'(LX_V - x_c);
        assign ry0_next[k] = PW'(E0_DX) * PW'(y_c - TY_V);
        assign ry1_next[k] = PW'(E1_DX) * PW'(y_c - MY_V);

        assign colx_next[k] = (x_c >= BAR_X0 && x_c < BAR_X1) ||
                              (x_c >= BAR_X2 && x_c < BAR_X3);
        assign rowy_next[k] = (y_c >= BAR_Y0 && y_c < BAR_Y1);
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            for (int k = 0; k < SUBSAMPLES; k++)
            begin
                dx2_reg[k] <= dx2_next[k];
                dy2_reg[k] <= dy2_next[k];
                cx0_reg[k] <= cx0_next[k];
                cx1_reg[k] <= cx1_next[k];
                cx2_reg[k] <= cx2_next[k];
                ry0_reg[k] <= ry0_next[k];
                ry1_reg[k] <= ry1_next[k];
            end
            colx_reg <= colx_next;
            rowy_reg <= rowy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: classify each subsample
    //   cov: inside radius plus half stroke
    //   hit: covered and on the ring or the glyph (takes glyph color)
    // ------------------------------------------------------------------
    logic [TOTAL-1:0] cov_next;
    logic [TOTAL-1:0] cov_reg;
    logic [TOTAL-1:0] hit_next;
    logic [TOTAL-1:0] hit_reg;

    for (genvar sy = 0; sy < SUBSAMPLES; sy++)
    begin : g_row
        for (genvar sx = 0; sx < SUBSAMPLES; sx++)
        begin : g_col
            logic [D2_W:0]        d2_s;
            logic signed [EW-1:0] e0_s;
            logic signed [EW-1:0] e1_s;
            logic signed [EW-1:0] e2_s;
            logic                 ring_s;
            logic                 tri_s;
            logic                 glyph_s;

            assign d2_s   = {1'b0, dx2_reg[sx]} + {1'b0, dy2_reg[sy]};
            assign e0_s   = EW'(ry0_reg[sy]) + EW'(cx0_reg[sx]);
            assign e1_s   = EW'(ry1_reg[sy]) + EW'(cx1_reg[sx]);
            assign e2_s   = EW'(cx2_reg[sx]);
            assign ring_s = (d2_s >= INNER2_V);
            // edges included: all non-negative or all non-positive
            assign tri_s  = (e0_s >= 0 && e1_s >= 0 && e2_s >= 0) ||
                            (e0_s <= 0 && e1_s <= 0 && e2_s <= 0);
            assign glyph_s = glyph_mode_reg ? (colx_reg[sx] && rowy_reg[sy]) : tri_s;

            assign cov_next[sy*SUBSAMPLES + sx] = (d2_s <= OUTER2_V);
            assign hit_next[sy*SUBSAMPLES + sx] = (d2_s <= OUTER2_V) && (ring_s || glyph_s);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[1])
        begin
            cov_reg <= cov_next;
            hit_reg <= hit_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: subsample counts
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] ncov_next;
    logic [CNT_W-1:0] ncov_reg;
    logic [CNT_W-1:0] nhit_next;
    logic [CNT_W-1:0] nhit_reg;

    always_comb
    begin
        ncov_next = '0;
        nhit_next = '0;
        for (int i = 0; i < TOTAL; i++)
        begin
            ncov_next = ncov_next + CNT_W'(cov_reg[i]);
            nhit_next = nhit_next + CNT_W'(hit_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[2])
        begin
            ncov_reg <= ncov_next;
            nhit_reg <= nhit_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: channel sums and alpha numerator
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] ndisc;
    logic [SUM_W-1:0] sum_next [NUM_CH];
    logic [SUM_W-1:0] sum_reg  [NUM_CH];

    assign ndisc = ncov_reg - nhit_reg;

    always_comb
    begin
        for (int c = 0; c < agp_pkg::CH_ALPHA; c++)
        begin
            sum_next[c] = SUM_W'(nhit_reg) * SUM_W'(glyph_color_reg[CH_W*c +: CH_W]) +
                          SUM_W'(ndisc)    * SUM_W'(disc_color_reg[CH_W*c +: CH_W]);
        end
        sum_next[agp_pkg::CH_ALPHA] = SUM_W'(ncov_reg) * SUM_W'(8'd255);
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[3])
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: (2 sum + TOTAL) times reciprocal of 2 TOTAL
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  num_s     [NUM_CH];
    logic [PROD_W-1:0] prod_next [NUM_CH];
    logic [PROD_W-1:0] prod_reg  [NUM_CH];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            num_s[c]     = NUM_W'({sum_reg[c], 1'b0}) + NUM_W'(TOTAL);
            prod_next[c] = PROD_W'(num_s[c]) * RECIP_V;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[4])
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: quotient into the output register (never exceeds 255)
    // ------------------------------------------------------------------
    logic [CH_W-1:0] out_next [NUM_CH];
    logic [CH_W-1:0] out_reg  [NUM_CH];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            out_next[c] = prod_reg[c][RSH +: CH_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[5])
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                out_reg[c] <= out_next[c];
            end
        end
    end

    assign blue_out  = out_reg[agp_pkg::CH_BLUE];
    assign green_out = out_reg[agp_pkg::CH_GREEN];
    assign red_out   = out_reg[agp_pkg::CH_RED];
    assign alpha_out = out_reg[agp_pkg::CH_ALPHA];

endmodule

FILE: hdl/agp_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// agp_checker: port-level checks for the antialiased glyph pixel unit
// Result handshake and premultiplied-color consistency of each transaction.
// ============================================================================

module agp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [agp_pkg::CH_W-1:0]      blue_out,
    input logic [agp_pkg::CH_W-1:0]      green_out,
    input logic [agp_pkg::CH_W-1:0]      red_out,
    input logic [agp_pkg::CH_W-1:0]      alpha_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(blue_out) && $stable(green_out) &&
                                    $stable(red_out) && $stable(alpha_out))
        else $error("result payload changed while stalled");

    // an uncovered pixel is fully transparent black
    a_clear_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alpha_out == '0 |-> blue_out == '0 && green_out == '0 &&
                                         red_out == '0)
        else $error("color on a pixel with zero alpha");

    // premultiplied: no channel exceeds alpha
    a_premult: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blue_out <= alpha_out && green_out <= alpha_out &&
                      red_out <= alpha_out)
        else $error("color channel above alpha");

endmodule

bind antialiased_glyph_pixel_unit agp_checker u_agp_checker (.*);
